// ===== design/sha1_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types and constants for the sha-1 hash engine: the queue item that
// passes from the input stage to the hash core, and the engine constants.
// ----------------------------------------------------------------------------
package sha1_pkg;

  // one classified input transaction, as it waits in the queue
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } item_t;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [31:0] H0_INIT = 32'h6745_2301;
  localparam logic [31:0] H1_INIT = 32'hEFCD_AB89;
  localparam logic [31:0] H2_INIT = 32'h98BA_DCFE;
  localparam logic [31:0] H3_INIT = 32'h1032_5476;
  localparam logic [31:0] H4_INIT = 32'hC3D2_E1F0;

  localparam logic [31:0] K_ROUND0 = 32'h5A82_7999;
  localparam logic [31:0] K_ROUND1 = 32'h6ED9_EBA1;
  localparam logic [31:0] K_ROUND2 = 32'h8F1B_BCDC;
  localparam logic [31:0] K_ROUND3 = 32'hCA62_C1D6;

  localparam logic [7:0] PAD_MARKER = 8'h80;

  localparam int NUM_ROUNDS  = 80;
  localparam int NUM_DIGEST  = 5;
  localparam int BLOCK_WORDS = 16;

endpackage
`default_nettype wire

// ===== design/sha1_hash_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_hash_engine
// SHA-1 digest engine taking one message byte per transaction.
// ----------------------------------------------------------------------------
// The engine accepts message bytes into a small queue and hashes them in a
// core that runs one sha-1 round per clock. The core packs each byte into
// the schedule as it arrives, and every full 64-byte block then runs through
// the 80 rounds and the chaining add; the core takes no new byte from the
// queue while it compresses, pads or emits. A transaction with tlast set ends
// the message: the core then writes the padding one byte per cycle, followed
// by one or two block compressions, and delivers the five digest
// words h0..h4 on the result channel, after which it starts the next message
// from the initial chaining values. Transactions with tuser set and tlast
// clear carry no byte and are dropped.
// ----------------------------------------------------------------------------
module sha1_hash_engine
  import sha1_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tuser,   // [0] no_byte
  input  wire logic        in_tlast,   // end_of_message
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [31:0] out_tdata,  // [31:0] digest_word
  output      logic [2:0]  out_tuser,  // [2:0] word_index
  output      logic        out_tlast   // last_word
);

  logic  front_valid;
  logic  front_ready;
  item_t front_item;
  logic  queue_valid;
  logic  queue_ready;
  item_t queue_item;

  sha1_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_tvalid),
    .in_ready          (in_tready),
    .in_data_byte      (in_tdata),
    .in_no_byte        (in_tuser),
    .in_end_of_message (in_tlast),
    .item_valid        (front_valid),
    .item_ready        (front_ready),
    .item              (front_item)
  );

  sha1_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_item  (front_item),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_item   (queue_item)
  );

  sha1_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (queue_valid),
    .item_ready      (queue_ready),
    .item            (queue_item),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_digest_word (out_tdata),
    .out_word_index  (out_tuser),
    .out_last_word   (out_tlast)
  );

endmodule
`default_nettype wire

// ===== design/sha1_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_front
// Input stage: registers each transaction and classifies it; items that
// carry neither a byte nor an end of message are dropped here.
// ----------------------------------------------------------------------------
module sha1_front
  import sha1_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_no_byte,
  input  wire logic       in_end_of_message,
  output      logic       item_valid,
  input  wire logic       item_ready,
  output      item_t      item
);

  logic  valid_r;
  item_t item_r;
  logic  keep;

  assign keep       = !in_no_byte || in_end_of_message;
  assign in_ready   = !valid_r || item_ready;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= keep;
    end else if (item_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.data_byte      <= in_data_byte;
      item_r.has_byte       <= !in_no_byte;
      item_r.end_of_message <= in_end_of_message;
    end
  end

endmodule
`default_nettype wire

// ===== design/sha1_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_queue
// Small first-in first-out queue between the input stage and the hash core.
// ----------------------------------------------------------------------------
module sha1_queue
  import sha1_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push_valid,
  output      logic  push_ready,
  input  wire item_t push_item,
  output      logic  pop_valid,
  input  wire logic  pop_ready,
  output      item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  item_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != CNT_FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ===== design/sha1_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_core
// Hash core: packs bytes into the message schedule, runs one sha-1 round per
// cycle, pads the message tail and hands out the five digest words.
// ----------------------------------------------------------------------------
module sha1_core
  import sha1_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        item_valid,
  output      logic        item_ready,
  input  wire item_t       item,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [31:0] out_digest_word,
  output      logic [2:0]  out_word_index,
  output      logic        out_last_word
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PAD   = 5'b00010,
    S_ROUND = 5'b00100,
    S_ADD   = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  localparam logic [6:0] ROUND_LAST = 7'(NUM_ROUNDS - 1);
  localparam logic [2:0] EMIT_LAST  = 3'(NUM_DIGEST - 1);

  function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] res;
    if (rnd inside {[7'd0:7'd19]}) begin
      res = (b & c) | (~b & d);
    end else if (rnd inside {[7'd40:7'd59]}) begin
      res = (b & c) | (b & d) | (c & d);
    end else begin
      res = b ^ c ^ d;
    end
    return res;
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] rnd);
    logic [31:0] res;
    if (rnd inside {[7'd0:7'd19]}) begin
      res = K_ROUND0;
    end else if (rnd inside {[7'd20:7'd39]}) begin
      res = K_ROUND1;
    end else if (rnd inside {[7'd40:7'd59]}) begin
      res = K_ROUND2;
    end else begin
      res = K_ROUND3;
    end
    return res;
  endfunction

  state_t      state_r;
  state_t      state_nxt;
  logic [31:0] h_r      [NUM_DIGEST];
  logic [31:0] wv_r     [NUM_DIGEST];
  logic [31:0] sched_r  [BLOCK_WORDS];
  logic [23:0] acc_r;
  logic [5:0]  byte_cnt_r;
  logic [63:0] bit_cnt_r;
  logic [6:0]  round_r;
  logic        pad_r;
  logic        sent80_r;
  logic        padlen_r;
  logic [2:0]  emit_idx_r;
  logic        out_valid_r;
  logic [31:0] out_word_r;
  logic [2:0]  out_idx_r;
  logic        out_last_r;

  logic        pop;
  logic        put_en;
  logic [7:0]  put_val;
  logic [7:0]  pad_byte;
  logic [7:0]  len_sh;
  logic        word_done;
  logic        block_full;
  logic [31:0] new_w;
  logic [31:0] temp;
  logic        load_out;

  assign item_ready = (state_r == S_IDLE);
  assign pop        = item_valid && item_ready;

  // length bytes go out most significant first, from offset 56 on
  assign len_sh = 8'(bit_cnt_r >> {~byte_cnt_r[2:0], 3'b000});

  always_comb begin
    if (!sent80_r) begin
      pad_byte = PAD_MARKER;
    end else if (padlen_r || byte_cnt_r == 6'd56) begin
      pad_byte = len_sh;
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign put_en     = (pop && item.has_byte) || (state_r == S_PAD);
  assign put_val    = (state_r == S_PAD) ? pad_byte : item.data_byte;
  assign word_done  = put_en && (byte_cnt_r[1:0] == 2'b11);
  assign block_full = put_en && (byte_cnt_r == 6'd63);

  assign new_w = sched_r[13] ^ sched_r[8] ^ sched_r[2] ^ sched_r[0];
  assign temp  = {wv_r[0][26:0], wv_r[0][31:27]}
               + round_f(round_r, wv_r[1], wv_r[2], wv_r[3])
               + wv_r[4] + round_k(round_r) + sched_r[0];

  assign load_out = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (pop) begin
          if (block_full) begin
            state_nxt = S_ROUND;
          end else if (item.end_of_message) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (block_full) begin
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        if (round_r == ROUND_LAST) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        if (padlen_r) begin
          state_nxt = S_EMIT;
        end else if (pad_r) begin
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (load_out && emit_idx_r == EMIT_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and chaining state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      h_r[0]      <= H0_INIT;
      h_r[1]      <= H1_INIT;
      h_r[2]      <= H2_INIT;
      h_r[3]      <= H3_INIT;
      h_r[4]      <= H4_INIT;
      byte_cnt_r  <= '0;
      bit_cnt_r   <= '0;
      round_r     <= '0;
      pad_r       <= 1'b0;
      sent80_r    <= 1'b0;
      padlen_r    <= 1'b0;
      emit_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (put_en) begin
        byte_cnt_r <= byte_cnt_r + 1'b1;
      end
      if (pop) begin
        pad_r    <= item.end_of_message;
        sent80_r <= 1'b0;
        padlen_r <= 1'b0;
        if (item.has_byte) begin
          bit_cnt_r <= bit_cnt_r + 64'd8;
        end
      end
      if (state_r == S_PAD) begin
        sent80_r <= 1'b1;
        if (sent80_r && byte_cnt_r == 6'd56) begin
          padlen_r <= 1'b1;
        end
      end
      if (state_r == S_ROUND) begin
        round_r <= (round_r == ROUND_LAST) ? '0 : round_r + 1'b1;
      end
      if (state_r == S_ADD) begin
        for (int i = 0; i < NUM_DIGEST; i++) begin
          h_r[i] <= h_r[i] + wv_r[i];
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
        emit_idx_r  <= (emit_idx_r == EMIT_LAST) ? '0 : emit_idx_r + 1'b1;
        if (emit_idx_r == EMIT_LAST) begin
          // message done: back to the initial chaining state
          h_r[0]     <= H0_INIT;
          h_r[1]     <= H1_INIT;
          h_r[2]     <= H2_INIT;
          h_r[3]     <= H3_INIT;
          h_r[4]     <= H4_INIT;
          bit_cnt_r  <= '0;
          pad_r      <= 1'b0;
          sent80_r   <= 1'b0;
          padlen_r   <= 1'b0;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // schedule window, working variables and output payload
  always_ff @(posedge clk) begin
    if (put_en) begin
      acc_r <= {acc_r[15:0], put_val};
    end
    if (word_done) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        sched_r[i] <= sched_r[i+1];
      end
      sched_r[BLOCK_WORDS-1] <= {acc_r, put_val};
    end else if (state_r == S_ROUND) begin
      // window holds w[t..t+15]; push w[t+16]
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        sched_r[i] <= sched_r[i+1];
      end
      sched_r[BLOCK_WORDS-1] <= {new_w[30:0], new_w[31]};
    end
    if (block_full) begin
      for (int i = 0; i < NUM_DIGEST; i++) begin
        wv_r[i] <= h_r[i];
      end
    end else if (state_r == S_ROUND) begin
      wv_r[0] <= temp;
      wv_r[1] <= wv_r[0];
      wv_r[2] <= {wv_r[1][1:0], wv_r[1][31:2]};
      wv_r[3] <= wv_r[2];
      wv_r[4] <= wv_r[3];
    end
    if (load_out) begin
      out_word_r <= h_r[emit_idx_r];
      out_idx_r  <= emit_idx_r;
      out_last_r <= (emit_idx_r == EMIT_LAST);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_word_index  = out_idx_r;
  assign out_last_word   = out_last_r;

endmodule
`default_nettype wire

// ===== tb/sv/sha1_hash_engine_tb.sv =====
// ----------------------------------------------------------------------------
// sha1_hash_engine_tb
// Self-checking bench for the sha-1 hash engine. Messages are fed one byte
// per transaction, with dropped empty transactions mixed in. A behavioral
// sha-1 digest model works out the five digest words that each finished
// message must produce. The bench then compares every result transaction
// with the oldest predicted word. Both channels stall at random.
// ----------------------------------------------------------------------------
module sha1_hash_engine_tb;
  import sha1_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 300;
  localparam int RANDOM_ITEMS = 400;

  typedef struct packed {
    logic [7:0] data;
    logic       no_byte;
    logic       eom;
    logic       hold;    // wait for all digests before sending
    logic       steady;  // no idling on either side
  } msg_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  logic        calm = 1'b0;

  msg_item_t    pending[$];
  digest_word_t digest_expect[$];

  // digest model state
  logic [31:0] chain_h[5];
  logic [31:0] msg_block[16];
  logic [63:0] msg_bits;
  logic [5:0]  fill_count;

  int errors = 0;
  int stim_items = 0;
  int messages_hashed = 0;
  int bytes_hashed = 0;
  int words_checked = 0;
  int cycles = 0;

  sha1_hash_engine uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void sha1_restart();
    chain_h[0] = 32'h6745_2301;
    chain_h[1] = 32'hEFCD_AB89;
    chain_h[2] = 32'h98BA_DCFE;
    chain_h[3] = 32'h1032_5476;
    chain_h[4] = 32'hC3D2_E1F0;
    msg_bits   = '0;
    fill_count = '0;
  endfunction

  function automatic void sha1_compress();
    logic [31:0] w[80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) w[i] = msg_block[i];
    for (int i = 16; i < 80; i++) w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5A82_7999;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ED9_EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8F1B_BCDC;
      end else begin
        f = b ^ c ^ d;
        k = 32'hCA62_C1D6;
      end
      t = rotl(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rotl(b, 30); b = a; a = t;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d; chain_h[4] += e;
  endfunction

  // big-endian packing, each word fully overwritten before compression
  function automatic void sha1_absorb(input logic [7:0] b);
    msg_block[fill_count[5:2]][8*(3 - fill_count[1:0]) +: 8] = b;
    fill_count++;
    if (fill_count == 0) sha1_compress();
  endfunction

  function automatic void sha1_take_item(input logic [7:0] data, input logic no_byte,
                                         input logic eom);
    logic [63:0]  len;
    digest_word_t exp_entry;
    if (!no_byte) begin
      sha1_absorb(data);
      msg_bits += 64'd8;
      bytes_hashed++;
    end
    if (eom) begin
      len = msg_bits;
      sha1_absorb(8'h80);
      while (fill_count != 6'd56) sha1_absorb(8'h00);
      for (int i = 7; i >= 0; i--) sha1_absorb(len[8*i +: 8]);
      for (int i = 0; i < NUM_DIGEST; i++) begin
        exp_entry = '{word: chain_h[i], index: 3'(i), last: (i == NUM_DIGEST - 1)};
        digest_expect.insert(digest_expect.size(), exp_entry);
      end
      messages_hashed++;
      sha1_restart();
    end
  endfunction

  task automatic push_item(input logic [7:0] data, input logic no_byte, input logic eom,
                           input logic hold, input logic steady);
    msg_item_t entry;
    entry = '{data: data, no_byte: no_byte, eom: eom, hold: hold, steady: steady};
    pending.insert(pending.size(), entry);
  endtask

  // one message; an empty tail ends it with a transaction that carries no byte
  task automatic add_message(input int len, input bit empty_tail, input bit steady,
                             input bit hold);
    bit first;
    first = hold;
    if (len == 0) empty_tail = 1'b1;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 8) begin
        push_item(8'($urandom), 1'b1, 1'b0, first, steady);
        first = 1'b0;
      end
      push_item(8'($urandom), 1'b0, !empty_tail && (i == len - 1), first, steady);
      first = 1'b0;
      stim_items++;
    end
    if (empty_tail) begin
      push_item(8'($urandom), 1'b1, 1'b1, first, steady);
      stim_items++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d digest words outstanding", cycles,
               digest_expect.size());
      $display("FAILURE");
      $finish;
    end
  end

  // input driver
  always @(posedge clk) begin
    logic lazy;
    logic blocked;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      calm      <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      lazy    = 1'b1;
      blocked = 1'b1;
      if (pending.size() != 0) begin
        lazy = !pending[0].steady && ($urandom_range(99) < 15);
        // a just-accepted transaction may still add expectations this edge
        blocked = pending[0].hold && (in_tvalid || digest_expect.size() != 0);
      end
      if (!lazy && !blocked) begin
        in_tvalid <= 1'b1;
        in_tdata  <= pending[0].data;
        in_tuser  <= pending[0].no_byte;
        in_tlast  <= pending[0].eom;
        calm      <= pending[0].steady;
        void'(pending.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else        out_tready <= calm || ($urandom_range(99) >= 15);
  end

  // monitor: predict on accepted input, check accepted results
  always @(posedge clk) begin
    digest_word_t exp_word;
    if (rst_n) begin
      if (in_tvalid && in_tready) sha1_take_item(in_tdata, in_tuser, in_tlast);
      if (out_tvalid && out_tready) begin
        if (digest_expect.size() == 0) begin
          $error("unexpected digest transaction: word %h index %0d", out_tdata, out_tuser);
          errors++;
        end else begin
          exp_word = digest_expect.pop_front();
          words_checked++;
          if (out_tdata !== exp_word.word) begin
            $error("digest_word mismatch: expected %h, actual %h", exp_word.word, out_tdata);
            errors++;
          end
          if (out_tuser !== exp_word.index) begin
            $error("word_index mismatch: expected %0d, actual %0d", exp_word.index, out_tuser);
            errors++;
          end
          if (out_tlast !== exp_word.last) begin
            $error("last_word mismatch: expected %0b, actual %0b", exp_word.last, out_tlast);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    int boundary_lens[4];
    int msg_idx;
    int pick;
    int len;
    boundary_lens = '{55, 56, 63, 64};
    sha1_restart();
    foreach (msg_block[i]) msg_block[i] = '0;

    // directed: empty message, dropped transactions, "abc", extreme bytes
    push_item(8'hFF, 1'b1, 1'b1, 1'b0, 1'b0);
    push_item(8'h00, 1'b1, 1'b0, 1'b0, 1'b0);
    push_item(8'h61, 1'b0, 1'b0, 1'b0, 1'b0);
    push_item(8'h62, 1'b0, 1'b0, 1'b0, 1'b0);
    push_item(8'h63, 1'b0, 1'b1, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
    push_item(8'hFF, 1'b0, 1'b1, 1'b0, 1'b0);
    push_item(8'hFF, 1'b1, 1'b0, 1'b0, 1'b0);
    push_item(8'hFF, 1'b0, 1'b0, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    push_item(8'h00, 1'b1, 1'b1, 1'b0, 1'b0);
    push_item(8'h00, 1'b1, 1'b1, 1'b0, 1'b0);

    // random messages; the first ones sit on the padding boundaries
    stim_items = 0;
    msg_idx = 0;
    while (stim_items < RANDOM_ITEMS) begin
      if (msg_idx < 4) begin
        len = boundary_lens[msg_idx];
      end else begin
        pick = $urandom_range(99);
        if (pick < 60)      len = $urandom_range(0, 12);
        else if (pick < 90) len = $urandom_range(50, 70);
        else                len = $urandom_range(110, 135);
      end
      add_message(len, 1'($urandom_range(1)), msg_idx >= 2 && msg_idx < 6,
                  msg_idx == 0 || msg_idx == 4 || $urandom_range(9) == 0);
      msg_idx++;
    end

    while (pending.size() != 0 || in_tvalid) @(posedge clk);
    while (digest_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (digest_expect.size() != 0) begin
      $error("%0d digest words never arrived", digest_expect.size());
      errors++;
    end
    $display("hashed %0d messages (%0d bytes), checked %0d digest words in %0d cycles",
             messages_hashed, bytes_hashed, words_checked, cycles);
    $display("covered empty messages, empty tails, dropped transactions, padding boundaries");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d errors", errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/sha1_pkg.sv
design/sha1_front.sv
design/sha1_queue.sv
design/sha1_core.sv
design/sha1_hash_engine.sv
tb/sv/sha1_hash_engine_tb.sv
